// ===== src/mrrc_pkg.sv =====
// Shared definitions for the Modbus RTU response checker: codes, register
// indexes, the result record and the CRC-16 byte update.
// No dependencies.
`default_nettype none

package mrrc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;

    // Function codes carried by a response.
    localparam logic [7:0] FC_READ_HOLD    = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    // Expected response modes.
    localparam logic [1:0] MODE_READ_HOLD    = 2'd0;
    localparam logic [1:0] MODE_WRITE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_WRITE_MULTI  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_EXPECT_MODE       = 2'd0;
    localparam logic [1:0] CFG_EXPECTED_ADDRESS  = 2'd1;
    localparam logic [1:0] CFG_EXPECTED_QUANTITY = 2'd2;
    localparam logic [1:0] CFG_EXPECTED_REGISTER = 2'd3;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Verdict status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CRC       = 3'd1;
    localparam logic [2:0] ST_LENGTH    = 3'd2;
    localparam logic [2:0] ST_ADDRESS   = 3'd3;
    localparam logic [2:0] ST_EXCEPTION = 3'd4;
    localparam logic [2:0] ST_FUNCTION  = 3'd5;
    localparam logic [2:0] ST_DATA      = 3'd6;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Frame byte counter saturates at this value.
    localparam logic [8:0] BYTES_SAT = 9'd511;

    // Register value that turns off the write-single register echo check.
    localparam logic [15:0] REG_CHECK_OFF = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [7:0]  data_len;
    } t_result;

    // One byte of the reflected CRC-16, eight shift steps.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/mrrc_rx_if.sv =====
// Byte request channel into the Modbus RTU response checker.
// No dependencies.
`default_nettype none

interface mrrc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

`default_nettype wire

// ===== src/mrrc_res_if.sv =====
// Result channel out of the Modbus RTU response checker.
// No dependencies.
`default_nettype none

interface mrrc_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [7:0]  data_len;

    modport source (output valid, output kind, output status, output payload_byte,
                    output first_word, output second_word, output data_len,
                    input ready);
    modport sink   (input valid, input kind, input status, input payload_byte,
                    input first_word, input second_word, input data_len,
                    output ready);
endinterface

`default_nettype wire

// ===== src/mrrc_out_buf.sv =====
// Two-entry output buffer (result register plus skid entry) for checker results.
// Depends on mrrc_pkg and mrrc_res_if.
`default_nettype none

module mrrc_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire mrrc_pkg::t_result i_data,
    output logic                  o_ready,
    mrrc_res_if.source            o_res
);
    import mrrc_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop     = r_main_valid & o_res.ready;
    assign o_ready = ~r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            n_main_valid = r_skid_valid;
            n_main       = r_skid;
            n_skid_valid = 1'b0;
        end
        if (i_push) begin
            if (!n_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_res.valid        = r_main_valid;
    assign o_res.kind         = r_main.kind;
    assign o_res.status       = r_main.status;
    assign o_res.payload_byte = r_main.payload_byte;
    assign o_res.first_word   = r_main.first_word;
    assign o_res.second_word  = r_main.second_word;
    assign o_res.data_len     = r_main.data_len;

endmodule

`default_nettype wire

// ===== src/modbus_rtu_response_checker.sv =====
// Top level of the Modbus RTU response checker: frame tracking, CRC and verdict.
// Depends on mrrc_pkg, mrrc_rx_if, mrrc_res_if and mrrc_out_buf.
`default_nettype none

// Channel   Direction  Handshake      Carries
// i_rx      in         valid/ready    rx_byte, end_of_frame (one frame byte)
// o_res     out        valid/ready    kind, status, payload_byte, first_word,
//                                     second_word, data_len
// i_cfg_*   in         write enable   register index and write data
//
// Each accepted byte request is fully handled in the cycle it is accepted, so the
// block takes one byte per clock; results reach o_res from the output buffer registers.
// The rate is set by the combinational CRC byte update and the verdict compares.
// Results queue in a two-entry output buffer; i_rx.ready drops only while both
// entries hold results that the sink has not taken.
// Reset is synchronous and active low; it restores the register defaults and
// an empty frame, with no clearing pass.
module modbus_rtu_response_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mrrc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [mrrc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mrrc_rx_if.sink                                 i_rx,
    mrrc_res_if.source                              o_res
);
    import mrrc_pkg::*;

    // Configuration registers.
    logic [1:0]  r_expect_mode;
    logic [7:0]  r_expected_address;
    logic [6:0]  r_expected_quantity;
    logic [15:0] r_expected_register;

    // Frame state. Everything here returns to its empty-frame value after the
    // flagged final byte of each frame.
    logic [15:0] r_crc,          n_crc;
    logic [8:0]  r_bytes_seen,   n_bytes_seen;
    logic [7:0]  r_held [0:1];
    logic [7:0]  n_held [0:1];
    logic [7:0]  r_address,      n_address;
    logic [7:0]  r_function,     n_function;
    logic [7:0]  r_count,        n_count;
    logic [15:0] r_first,        n_first;
    logic [15:0] r_second,       n_second;

    logic        accept;
    logic        last;
    logic [7:0]  rx_byte;
    logic [8:0]  idx;
    logic [9:0]  len_ext;
    logic [15:0] rx_crc;
    logic        crc_bad;
    logic [2:0]  verdict;
    logic        in_window;
    logic        push;
    t_result     result;
    logic        buf_ready;

    assign accept  = i_rx.valid & i_rx.ready;
    assign last    = i_rx.end_of_frame;
    assign rx_byte = i_rx.rx_byte;
    assign idx     = r_bytes_seen;
    assign i_rx.ready = buf_ready;

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_mode       <= MODE_READ_HOLD;
            r_expected_address  <= 8'h00;
            r_expected_quantity <= 7'd0;
            r_expected_register <= REG_CHECK_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECT_MODE:       r_expect_mode       <= i_cfg_data[1:0];
                CFG_EXPECTED_ADDRESS:  r_expected_address  <= i_cfg_data[7:0];
                CFG_EXPECTED_QUANTITY: r_expected_quantity <= i_cfg_data[6:0];
                CFG_EXPECTED_REGISTER: r_expected_register <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-byte frame update. The CRC runs two bytes behind the input so that
    // the trailing two bytes (the received CRC) never enter it; the two-byte
    // delay line holds them until the final byte shows up.
    // ------------------------------------------------------------------
    always_comb begin
        n_crc        = (idx >= 9'd2) ? crc16_byte(r_crc, r_held[0]) : r_crc;
        n_held[0]    = r_held[1];
        n_held[1]    = rx_byte;
        n_bytes_seen = (r_bytes_seen == BYTES_SAT) ? BYTES_SAT : r_bytes_seen + 9'd1;
        n_address    = r_address;
        n_function   = r_function;
        n_count      = r_count;
        n_first      = r_first;
        n_second     = r_second;
        case (idx)
            9'd0: n_address  = rx_byte;
            9'd1: n_function = rx_byte;
            9'd2: begin
                n_count = rx_byte;
                n_first = {rx_byte, 8'h00};
            end
            9'd3: n_first  = {r_first[15:8], rx_byte};
            9'd4: n_second = {rx_byte, 8'h00};
            9'd5: n_second = {r_second[15:8], rx_byte};
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Verdict for a final byte. The received CRC is low byte first, so the
    // newer held byte is its low half and the current byte its high half.
    // ------------------------------------------------------------------
    assign len_ext = {1'b0, n_bytes_seen};
    assign rx_crc  = {rx_byte, r_held[1]};
    assign crc_bad = (n_bytes_seen < 9'd4) || (rx_crc != n_crc);

    always_comb begin
        verdict = ST_OK;
        if (crc_bad) begin
            verdict = ST_CRC;
        end else begin
            case (r_expect_mode)
                MODE_READ_HOLD: begin
                    if (n_bytes_seen < 9'd5) begin
                        verdict = ST_LENGTH;
                    end else if (n_address != r_expected_address) begin
                        verdict = ST_ADDRESS;
                    end else if (n_function == (FC_READ_HOLD | EXC_FLAG)) begin
                        verdict = ST_EXCEPTION;
                    end else if (n_function != FC_READ_HOLD) begin
                        verdict = ST_FUNCTION;
                    end else if (len_ext != 10'd5 + {2'b00, n_count}) begin
                        verdict = ST_LENGTH;
                    end else if (n_count[0]) begin
                        verdict = ST_DATA;
                    end else if ((r_expected_quantity != 7'd0)
                                 && (n_count != {r_expected_quantity, 1'b0})) begin
                        verdict = ST_DATA;
                    end
                end
                MODE_WRITE_SINGLE: begin
                    if (n_bytes_seen != 9'd8) begin
                        verdict = ST_LENGTH;
                    end else if (n_address != r_expected_address) begin
                        verdict = ST_ADDRESS;
                    end else if (n_function == (FC_WRITE_SINGLE | EXC_FLAG)) begin
                        verdict = ST_EXCEPTION;
                    end else if (n_function != FC_WRITE_SINGLE) begin
                        verdict = ST_FUNCTION;
                    end else if ((r_expected_register != REG_CHECK_OFF)
                                 && (n_first != r_expected_register)) begin
                        verdict = ST_DATA;
                    end
                end
                MODE_WRITE_MULTI: begin
                    if (n_bytes_seen != 9'd8) begin
                        verdict = ST_LENGTH;
                    end else if (n_address != r_expected_address) begin
                        verdict = ST_ADDRESS;
                    end else if (n_function == (FC_WRITE_MULTI | EXC_FLAG)) begin
                        verdict = ST_EXCEPTION;
                    end else if (n_function != FC_WRITE_MULTI) begin
                        verdict = ST_FUNCTION;
                    end
                end
                default: verdict = ST_FUNCTION;
            endcase
        end
    end

    // In read mode, data bytes (index 3 up to 2 + byte count) stream out as
    // tentative payload results before the frame is known to be good.
    assign in_window = (r_expect_mode == MODE_READ_HOLD) && (idx >= 9'd3)
                       && ({1'b0, idx} < {2'b00, n_count} + 10'd3);

    always_comb begin
        result              = '0;
        result.kind         = KIND_PAYLOAD;
        result.status       = ST_OK;
        if (last) begin
            result.kind   = KIND_VERDICT;
            result.status = verdict;
            case (r_expect_mode)
                MODE_READ_HOLD: result.data_len = n_count;
                MODE_WRITE_SINGLE, MODE_WRITE_MULTI: begin
                    result.first_word  = n_first;
                    result.second_word = n_second;
                end
                default: ;
            endcase
        end else begin
            result.payload_byte = rx_byte;
        end
    end

    assign push = accept && (last || in_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && last)) begin
            r_crc        <= CRC_INIT;
            r_bytes_seen <= 9'd0;
            r_held[0]    <= 8'h00;
            r_held[1]    <= 8'h00;
            r_address    <= 8'h00;
            r_function   <= 8'h00;
            r_count      <= 8'h00;
            r_first      <= 16'h0000;
            r_second     <= 16'h0000;
        end else if (accept) begin
            r_crc        <= n_crc;
            r_bytes_seen <= n_bytes_seen;
            r_held[0]    <= n_held[0];
            r_held[1]    <= n_held[1];
            r_address    <= n_address;
            r_function   <= n_function;
            r_count      <= n_count;
            r_first      <= n_first;
            r_second     <= n_second;
        end
    end

    mrrc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (result),
        .o_ready (buf_ready),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // A final byte always leaves an empty frame behind.
    a_frame_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_bytes_seen == 9'd0) && (r_crc == CRC_INIT))
        else $error("frame state not reloaded after final byte");

    // The byte counter moves by one per accepted non-final byte until it saturates.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !last && (r_bytes_seen != BYTES_SAT))
            |=> (r_bytes_seen == $past(r_bytes_seen) + 9'd1))
        else $error("byte counter did not advance");

    // A payload result carries only the data byte.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_PAYLOAD))
            |-> (o_res.status == ST_OK) && (o_res.first_word == 16'h0000)
                && (o_res.second_word == 16'h0000) && (o_res.data_len == 8'h00))
        else $error("payload result carries verdict fields");

    // Payload results only come from read mode.
    a_payload_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !last) |-> (r_expect_mode == MODE_READ_HOLD))
        else $error("payload result outside read mode");
`endif

endmodule

`default_nettype wire
